// ----- design/touch_pad_calibrate_and_detect_macros.svh -----
// Assertion macros shared by the touch pad checker.
`ifndef TOUCH_PAD_CALIBRATE_AND_DETECT_MACROS_SVH
`define TOUCH_PAD_CALIBRATE_AND_DETECT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TPCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch pad check failed");

// Next-cycle implication, disabled while reset is low.
`define TPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch pad check failed");

`endif

// ----- design/tpcd_pkg.sv -----
// Shared types, codes and constants of the touch pad calibrate and detect block.
`timescale 1ns / 1ps

package tpcd_pkg;

    localparam int FIELD_W           = 16;
    localparam int CALIB_SAMPLES_DEF = 10;
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int MEAN_FIRST        = 2;
    localparam int MEAN_COUNT        = 6;
    localparam int CFG_IDX_W         = 2;
    localparam int SPC_W             = 4;
    localparam int LOCK_W            = 2;

    localparam logic [LOCK_W-1:0]  LOCK_RELOAD   = 2'd3;
    localparam logic [FIELD_W-1:0] MARGIN_RESET  = 16'd100;
    localparam logic [FIELD_W-1:0] FULL_RESET    = 16'd65535;
    localparam logic [SPC_W-1:0]   SPC_RESET     = 4'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPC    = 2'd2;

    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;
    localparam logic KIND_SCAN   = 1'b0;
    localparam logic KIND_CAL    = 1'b1;

    typedef struct packed {
        logic               command;
        logic [FIELD_W-1:0] sample;
    } t_tpcd_in;

    typedef struct packed {
        logic               result_kind;
        logic               pressed;
        logic [FIELD_W-1:0] peak_value;
        logic [FIELD_W-1:0] baseline;
        logic               calib_fail;
    } t_tpcd_out;

    // Control handed to each sorting cell.
    typedef struct packed {
        logic we;
        logic below;
        logic at;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_CAL,
        ST_START,
        ST_DIV,
        ST_SCAN
    } t_tpcd_state;

endpackage

// ----- design/tpcd_cell.sv -----
// One cell of the insertion-sort chain that holds a calibration sample.
`timescale 1ns / 1ps

module tpcd_cell
    import tpcd_pkg::*;
#(
    parameter int W = SAMPLE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  t_cell_ctl    i_ctl,
    input  logic [W-1:0] i_val,
    input  logic [W-1:0] i_prev_val,
    input  logic         i_prev_gt,
    output logic [W-1:0] o_val,
    output logic         o_gt
);

    logic [W-1:0] r_val;

    // A filled cell above the new value shifts up; the first such cell or the
    // empty slot takes either its lower neighbor or the new value.
    assign o_gt  = i_ctl.below && (r_val > i_val);
    assign o_val = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we && (o_gt || i_ctl.at)) begin
            r_val <= i_prev_gt ? i_prev_val : i_val;
        end
    end

endmodule

// ----- design/tpcd_div6.sv -----
// Division of the calibration sum by the mean count through a scaled reciprocal.
`timescale 1ns / 1ps

module tpcd_div6
    import tpcd_pkg::*;
#(
    parameter int SUM_W = SAMPLE_WIDTH_DEF + 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SUM_W-1:0]   i_sum,
    output logic               o_done,
    output logic [FIELD_W-1:0] o_quo
);

    // The reciprocal is rounded up; its error times any SUM_W-bit sum stays
    // below one unit after the shift, so the quotient is exact.
    localparam int              SHIFT   = SUM_W + 3;
    localparam longint unsigned RECIP   =
        ((64'd1 << SHIFT) + MEAN_COUNT - 1) / MEAN_COUNT;
    localparam int              RECIP_W = SUM_W + 1;
    localparam int              PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    logic               r_busy;
    logic               r_done;
    logic [SUM_W-1:0]   r_sum;
    logic [FIELD_W-1:0] r_quo;
    logic [PROD_W-1:0]  w_prod;

    assign w_prod = PROD_W'(r_sum) * PROD_W'(RECIP_C);

    // The sum is registered first, then multiplied in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= i_sum;
        end
        if (r_busy) begin
            r_quo <= FIELD_W'(w_prod >> SHIFT);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- design/touch_pad_calibrate_and_detect.sv -----
// Top level of the capacitive touch pad calibrate and detect block.
//
// Accepts one item per clock while calibrating or scanning and the output queue
// has room. Calibration inserts each sample into a chain of sorting cells.
// After the last calibration sample the input is held off while sorted entries
// two through seven are summed, the registered sum is multiplied by a scaled
// reciprocal of six, and the baseline result is queued. A scan sample that ends
// a group queues the group result in the same cycle. A two-item output queue
// lets a new item enter while one result still waits to be taken.
`timescale 1ns / 1ps

module touch_pad_calibrate_and_detect
    import tpcd_pkg::*;
#(
    parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF,
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FIELD_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_tpcd_in             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_tpcd_out            o_out
);

    localparam int SW    = SAMPLE_WIDTH;
    // Samples never carry more bits than the input field.
    localparam int VAL_W = (SW < FIELD_W) ? SW : FIELD_W;
    localparam int SUM_W = VAL_W + 3;
    localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
    localparam int VAL_N = (CALIB_SAMPLES > 8) ? CALIB_SAMPLES : 8;
    localparam int CMP_W = ((SW > FIELD_W) ? SW : FIELD_W) + 1;

    // Configuration registers.
    logic [FIELD_W-1:0] r_margin;
    logic [FIELD_W-1:0] r_full;
    logic [SPC_W-1:0]   r_spc;

    // Control state.
    t_tpcd_state        r_state;
    t_tpcd_state        n_state;
    logic [CNT_W-1:0]   r_cal_cnt;
    logic [SPC_W-1:0]   r_grp;
    logic [SW-1:0]      r_max;
    logic [LOCK_W-1:0]  r_lock;
    logic [FIELD_W-1:0] r_base;

    // Output queue.
    t_tpcd_out          r_q [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_qcnt;

    logic               w_accept;
    logic               w_restart;
    logic               w_cal_we;
    logic               w_scan;
    logic               w_div_start;
    logic               w_div_done;
    logic [FIELD_W-1:0] w_quo;
    logic [SUM_W-1:0]   w_sum;
    logic [SW-1:0]      w_s;
    logic [31:0]        w_s32;
    logic               w_cal_last;
    logic [SW-1:0]      w_max_new;
    logic [SPC_W:0]     w_grp_inc;
    logic [SPC_W:0]     w_spc_eff;
    logic               w_grp_end;
    logic               w_hit;
    logic               w_push;
    logic               w_pop;
    t_tpcd_out          w_push_data;
    logic               w_can_take;

    t_cell_ctl          w_ctl   [CALIB_SAMPLES];
    logic [SW-1:0]      w_chv   [CALIB_SAMPLES+1];
    logic               w_chg   [CALIB_SAMPLES+1];
    logic [SW-1:0]      w_sumv  [VAL_N];

    // Only the low bits of the sample count, up to the field width.
    assign w_s32 = 32'(i_in.sample);
    assign w_s   = w_s32[SW-1:0];

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_restart = w_accept && (i_in.command == CMD_RESTART);
    assign w_cal_we  = w_accept && (i_in.command == CMD_SAMPLE) && (r_state == ST_CAL);
    assign w_scan    = w_accept && (i_in.command == CMD_SAMPLE) && (r_state == ST_SCAN);
    assign w_cal_last = (r_cal_cnt == CNT_W'(CALIB_SAMPLES - 1));

    // Sorting chain.
    assign w_chv[0] = '0;
    assign w_chg[0] = 1'b0;

    for (genvar gi = 0; gi < CALIB_SAMPLES; gi++) begin : g_cell
        assign w_ctl[gi] = '{we:    w_cal_we,
                             below: (CNT_W'(gi) < r_cal_cnt),
                             at:    (CNT_W'(gi) == r_cal_cnt)};
        tpcd_cell #(.W(SW)) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[gi]),
            .i_val      (w_s),
            .i_prev_val (w_chv[gi]),
            .i_prev_gt  (w_chg[gi]),
            .o_val      (w_chv[gi+1]),
            .o_gt       (w_chg[gi+1])
        );
    end

    // Positions past the chain read as zero.
    for (genvar gk = 0; gk < VAL_N; gk++) begin : g_sumv
        if (gk < CALIB_SAMPLES) begin : g_real
            assign w_sumv[gk] = w_chv[gk+1];
        end else begin : g_zero
            assign w_sumv[gk] = '0;
        end
    end

    always_comb begin
        logic [SUM_W-1:0] v_sum;
        v_sum = '0;
        for (int k = 0; k < MEAN_COUNT; k++) begin
            v_sum = v_sum + SUM_W'(w_sumv[MEAN_FIRST + k]);
        end
        w_sum = v_sum;
    end

    tpcd_div6 #(.SUM_W(SUM_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_sum),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Scan group decision.
    assign w_max_new = (w_s > r_max) ? w_s : r_max;
    assign w_grp_inc = {1'b0, r_grp} + 1'b1;
    assign w_spc_eff = (r_spc == '0) ? (SPC_W+1)'(1) : {1'b0, r_spc};
    assign w_grp_end = (w_grp_inc >= w_spc_eff);
    assign w_hit     = (CMP_W'(w_max_new) > (CMP_W'(r_base) + CMP_W'(r_margin)));

    // State machine.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CAL: begin
                if (w_cal_we && w_cal_last) begin
                    n_state = ST_START;
                end
            end
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_restart) begin
                    n_state = ST_CAL;
                end
            end
            default: n_state = ST_CAL;
        endcase
    end

    always_comb begin
        w_can_take  = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_CAL:   w_can_take  = 1'b1;
            ST_START: w_div_start = 1'b1;
            ST_DIV:   w_can_take  = 1'b0;
            ST_SCAN:  w_can_take  = 1'b1;
            default:  w_can_take  = 1'b0;
        endcase
    end

    assign o_in_ready = w_can_take && (r_qcnt != 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CAL;
            r_margin  <= MARGIN_RESET;
            r_full    <= FULL_RESET;
            r_spc     <= SPC_RESET;
            r_cal_cnt <= '0;
            r_grp     <= '0;
            r_max     <= '0;
            r_lock    <= '0;
            r_base    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MARGIN: r_margin <= i_cfg_data;
                    CFG_FULL:   r_full   <= i_cfg_data;
                    CFG_SPC:    r_spc    <= i_cfg_data[SPC_W-1:0];
                    default:    r_spc    <= r_spc;
                endcase
            end
            if (w_restart) begin
                r_cal_cnt <= '0;
                r_grp     <= '0;
                r_max     <= '0;
                r_lock    <= '0;
            end else if (w_cal_we) begin
                r_cal_cnt <= w_cal_last ? '0 : r_cal_cnt + 1'b1;
            end else if (w_scan) begin
                if (w_grp_end) begin
                    r_grp <= '0;
                    r_max <= '0;
                    if (w_hit) begin
                        r_lock <= LOCK_RELOAD - 1'b1;
                    end else if (r_lock != '0) begin
                        r_lock <= r_lock - 1'b1;
                    end
                end else begin
                    r_grp <= w_grp_inc[SPC_W-1:0];
                    r_max <= w_max_new;
                end
            end else if (w_div_done) begin
                r_base <= w_quo;
                r_grp  <= '0;
                r_max  <= '0;
            end
        end
    end

    // Result assembly and output queue.
    always_comb begin
        w_push_data = '0;
        if (w_div_done) begin
            w_push_data.result_kind = KIND_CAL;
            w_push_data.baseline    = w_quo;
            w_push_data.calib_fail  = (w_quo > (r_full >> 1));
        end else begin
            w_push_data.result_kind = KIND_SCAN;
            w_push_data.pressed     = w_hit && (r_lock == '0);
            w_push_data.peak_value  = FIELD_W'(w_max_new);
            w_push_data.baseline    = r_base;
        end
    end

    assign w_push = w_div_done || (w_scan && w_grp_end);
    assign w_pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_qcnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            priority if (w_push && !w_pop) begin
                r_qcnt <= r_qcnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_qcnt <= r_qcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_push_data;
        end
    end

    assign o_out_valid = (r_qcnt != '0);
    assign o_out       = r_q[r_rp];

endmodule

// ----- design/tpcd_checker.sv -----
// Port-level checker of the touch pad block and its bind.
`timescale 1ns / 1ps
`include "touch_pad_calibrate_and_detect_macros.svh"

module tpcd_checker
    import tpcd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [FIELD_W-1:0]   i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input t_tpcd_in             i_in,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_tpcd_out            o_out
);

    // A result held back by the consumer keeps its value.
    `TPCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))

    // A scan decision never reports a failed calibration.
    `TPCD_ASSERT_NOW(a_scan_no_fail, i_clk, i_rst_n, o_out_valid && (o_out.result_kind == KIND_SCAN), !o_out.calib_fail)

    // A calibration result carries no touch and no peak.
    `TPCD_ASSERT_NOW(a_cal_clean, i_clk, i_rst_n, o_out_valid && (o_out.result_kind == KIND_CAL), !o_out.pressed && (o_out.peak_value == '0))

    // A reported touch always peaks above the baseline.
    `TPCD_ASSERT_NOW(a_press_peak, i_clk, i_rst_n, o_out_valid && o_out.pressed, o_out.peak_value > o_out.baseline)

    // A restart item makes no result.
    `TPCD_ASSERT_NEXT(a_restart_quiet, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in.command == CMD_RESTART) && !o_out_valid, !o_out_valid)

endmodule

bind touch_pad_calibrate_and_detect tpcd_checker u_tpcd_checker (.*);

// ----- tb/touch_pad_calibrate_and_detect_tb.sv -----
// Self-checking testbench for the touch pad calibrate and detect block.
`timescale 1ns / 1ps

module touch_pad_calibrate_and_detect_tb;
    import tpcd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int        SETTLE_CYCLES = 20;
    localparam int        DRAIN_CYCLES  = 30;
    localparam int        HOLD_CYCLES   = 300;
    localparam int        STALL_LIMIT   = 2000;
    localparam int        ITEM_TARGET   = 400;
    localparam int        FULL_COUNT    = 65535;
    localparam t_tpcd_out NO_REPORT     = '0;

    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [FIELD_W-1:0]   reg_val;
        t_tpcd_in             item;
        bit                   typed;
        t_tpcd_out            want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [FIELD_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_tpcd_in             i_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_tpcd_out            o_out;

    touch_pad_calibrate_and_detect uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Predictor copy of the registers and the detector state.
    logic [FIELD_W-1:0] margin_reg;
    logic [FIELD_W-1:0] full_reg;
    logic [SPC_W-1:0]   spc_reg;
    logic [FIELD_W-1:0] cal_sorted [CALIB_SAMPLES_DEF];
    int                 cal_taken;
    bit                 in_calibration;
    logic [FIELD_W-1:0] base_level;
    int                 grp_taken;
    logic [FIELD_W-1:0] grp_peak;
    int                 lock_left;

    t_tpcd_out awaited_reports[$];
    t_row      directed_rows[$];
    t_row      row_buf;
    t_tpcd_out head_report;

    int items_sent;
    int reports_checked;
    int cal_reports;
    int new_touches;
    int errors;
    int hold_asks;
    int hold_done;
    int quiet_cycles;
    int phase;
    int level;
    int cut;
    int scan_len;
    int ready_pick;
    bit burst;

    function automatic t_tpcd_in pad_item(input logic cmd, input logic [FIELD_W-1:0] value);
        t_tpcd_in it;
        it.command = cmd;
        it.sample  = value;
        return it;
    endfunction

    function automatic logic [FIELD_W-1:0] clamp16(input int v);
        if (v < 0)
            return '0;
        if (v > FULL_COUNT)
            return FULL_COUNT[FIELD_W-1:0];
        return v[FIELD_W-1:0];
    endfunction

    // Advances the predicted detector by one accepted item.
    function automatic void pad_response(input t_tpcd_in item, output bit produced,
                                         output t_tpcd_out res);
        int          pos;
        int unsigned level_sum;
        bit          touch;
        produced = 1'b0;
        res      = '0;
        if (item.command == CMD_RESTART) begin
            in_calibration = 1'b1;
            cal_taken      = 0;
            grp_taken      = 0;
            grp_peak       = '0;
            lock_left      = 0;
        end else if (in_calibration) begin
            pos = cal_taken;
            while (pos > 0 && cal_sorted[pos-1] > item.sample) begin
                cal_sorted[pos] = cal_sorted[pos-1];
                pos--;
            end
            cal_sorted[pos] = item.sample;
            cal_taken++;
            if (cal_taken >= CALIB_SAMPLES_DEF) begin
                level_sum = 0;
                for (int i = MEAN_FIRST; i < MEAN_FIRST + MEAN_COUNT; i++)
                    level_sum += 32'(cal_sorted[i]);
                base_level     = FIELD_W'(level_sum / MEAN_COUNT);
                in_calibration = 1'b0;
                cal_taken      = 0;
                grp_taken      = 0;
                grp_peak       = '0;
                res.result_kind = KIND_CAL;
                res.baseline    = base_level;
                res.calib_fail  = (base_level > (full_reg >> 1));
                produced        = 1'b1;
            end
        end else begin
            if (item.sample > grp_peak)
                grp_peak = item.sample;
            grp_taken++;
            // A group size of zero behaves like one.
            if (grp_taken >= spc_reg) begin
                touch = (int'(grp_peak) > int'(base_level) + int'(margin_reg));
                res.result_kind = KIND_SCAN;
                res.pressed     = touch && (lock_left == 0);
                res.peak_value  = grp_peak;
                res.baseline    = base_level;
                if (touch)
                    lock_left = int'(LOCK_RELOAD);
                if (lock_left != 0)
                    lock_left--;
                grp_taken = 0;
                grp_peak  = '0;
                produced  = 1'b1;
            end
        end
    endfunction

    function automatic void add_row(input logic cmd, input logic [FIELD_W-1:0] value,
                                    input bit typed, input t_tpcd_out want);
        t_row r;
        r.is_write = 1'b0;
        r.reg_idx  = '0;
        r.reg_val  = '0;
        r.item     = pad_item(cmd, value);
        r.typed    = typed;
        r.want     = want;
        directed_rows.push_back(r);
    endfunction

    function automatic int sender_gap(input bit no_gaps);
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic int pick_level();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 2000);
            1: return $urandom_range(0, FULL_COUNT);
            2: return 32717 + $urandom_range(0, 100);
            3: return $urandom_range(60000, FULL_COUNT);
            default: return FULL_COUNT;
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] cal_sample(input int center);
        if ($urandom_range(0, 9) == 0)
            return clamp16($urandom_range(0, FULL_COUNT));
        return clamp16(center + int'($urandom_range(0, 400)) - 200);
    endfunction

    // Scan samples cluster around the touch threshold so both outcomes occur.
    function automatic logic [FIELD_W-1:0] scan_sample();
        int top;
        int kind;
        top = int'(base_level) + int'(margin_reg);
        if (top > FULL_COUNT)
            top = FULL_COUNT;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            return clamp16($urandom_range(top > 200 ? top - 200 : 0, top));
        if (kind < 7)
            return clamp16(top + 1 + int'($urandom_range(0, 300)));
        if (kind == 7)
            return clamp16(top);
        return clamp16($urandom_range(0, FULL_COUNT));
    endfunction

    function automatic logic [FIELD_W-1:0] pick_margin();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return FULL_COUNT[FIELD_W-1:0];
            6, 7: return clamp16($urandom_range(0, FULL_COUNT));
            default: return clamp16($urandom_range(0, 300));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_MARGIN: margin_reg = data;
            CFG_FULL:   full_reg   = data;
            CFG_SPC:    spc_reg    = data[SPC_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one item and returns at the edge where it is accepted.
    task automatic push_item(input t_tpcd_in item, input int gap, input bit typed,
                             input t_tpcd_out want);
        bit        produced;
        t_tpcd_out res;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        items_sent++;
        pad_response(item, produced, res);
        if (produced)
            awaited_reports.push_back(typed ? want : res);
    endtask

    // Waits until every result is in and any silent work has finished.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [FIELD_W-1:0] want,
                                input logic [FIELD_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Output side: random ready pattern, plus one long hold when asked.
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_done != hold_asks) begin
                hold_done++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                ready_pick = $urandom_range(0, 19);
                if (ready_pick < 10) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(1, 30)) @(posedge i_clk);
                end else if (ready_pick < 18) begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (awaited_reports.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, got %p", $time, o_out);
            end else begin
                head_report = awaited_reports.pop_front();
                report_field("result_kind", FIELD_W'(head_report.result_kind),
                             FIELD_W'(o_out.result_kind));
                report_field("pressed", FIELD_W'(head_report.pressed), FIELD_W'(o_out.pressed));
                report_field("peak_value", head_report.peak_value, o_out.peak_value);
                report_field("baseline", head_report.baseline, o_out.baseline);
                report_field("calib_fail", FIELD_W'(head_report.calib_fail),
                             FIELD_W'(o_out.calib_fail));
                reports_checked++;
                if (o_out.result_kind == KIND_CAL)
                    cal_reports++;
                else if (o_out.pressed)
                    new_touches++;
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("touch_pad_calibrate_and_detect verification failed");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in       = '0;
        margin_reg = MARGIN_RESET;
        full_reg   = FULL_RESET;
        spc_reg    = SPC_RESET;
        foreach (cal_sorted[i])
            cal_sorted[i] = '0;
        cal_taken      = 0;
        in_calibration = 1'b1;
        base_level     = '0;
        grp_taken      = 0;
        grp_peak       = '0;
        lock_left      = 0;

        // Calibration on alternating extremes lands exactly on half scale.
        for (int i = 0; i < CALIB_SAMPLES_DEF - 1; i++)
            add_row(CMD_SAMPLE, (i % 2 == 0) ? 16'hFFFF : 16'h0000, 1'b0, NO_REPORT);
        add_row(CMD_SAMPLE, 16'h0000, 1'b1, t_tpcd_out'{KIND_CAL, 1'b0, 16'd0, 16'd32767, 1'b0});
        add_row(CMD_SAMPLE, 16'd40000, 1'b0, NO_REPORT);
        add_row(CMD_SAMPLE, 16'd0, 1'b0, NO_REPORT);
        add_row(CMD_SAMPLE, 16'd100, 1'b1,
                t_tpcd_out'{KIND_SCAN, 1'b1, 16'd40000, 16'd32767, 1'b0});
        // A second touch right away is held back by the lockout.
        add_row(CMD_SAMPLE, 16'hFFFF, 1'b0, NO_REPORT);
        add_row(CMD_SAMPLE, 16'hFFFF, 1'b0, NO_REPORT);
        add_row(CMD_SAMPLE, 16'hFFFF, 1'b1,
                t_tpcd_out'{KIND_SCAN, 1'b0, 16'hFFFF, 16'd32767, 1'b0});
        row_buf          = directed_rows[0];
        row_buf.is_write = 1'b1;
        row_buf.reg_idx  = CFG_SPC;
        row_buf.reg_val  = '0;
        directed_rows.push_back(row_buf);
        // Zero group size: every sample ends a scan. Two quiet scans free the lockout.
        add_row(CMD_SAMPLE, 16'd0, 1'b0, NO_REPORT);
        add_row(CMD_SAMPLE, 16'd32867, 1'b0, NO_REPORT);
        add_row(CMD_SAMPLE, 16'hFFFF, 1'b0, NO_REPORT);
        add_row(CMD_RESTART, 16'hFFFF, 1'b0, NO_REPORT);
        add_row(CMD_RESTART, 16'h0000, 1'b0, NO_REPORT);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_write) begin
                settle();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
            end else begin
                push_item(directed_rows[r].item, sender_gap(1'b0), directed_rows[r].typed,
                          directed_rows[r].want);
            end
        end

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            case (phase)
                0: begin
                    write_reg(CFG_MARGIN, clamp16($urandom_range(0, 300)));
                    write_reg(CFG_FULL, FULL_COUNT[FIELD_W-1:0]);
                    write_reg(CFG_SPC, 16'd1);
                end
                1: begin
                    write_reg(CFG_MARGIN, '0);
                    write_reg(CFG_FULL, '0);
                    write_reg(CFG_SPC, 16'd15);
                end
                2: begin
                    write_reg(CFG_MARGIN, FULL_COUNT[FIELD_W-1:0]);
                    write_reg(CFG_FULL, 16'd1);
                    write_reg(CFG_SPC, 16'd2);
                    write_reg(CFG_SPARE, clamp16($urandom_range(0, FULL_COUNT)));
                end
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        write_reg(CFG_MARGIN, pick_margin());
                    if ($urandom_range(0, 1) == 0)
                        write_reg(CFG_FULL, clamp16($urandom_range(0, 3) == 0 ?
                                  $urandom_range(0, 1) * FULL_COUNT :
                                  $urandom_range(0, FULL_COUNT)));
                    if ($urandom_range(0, 1) == 0)
                        write_reg(CFG_SPC, ($urandom_range(0, 5) == 0) ?
                                  16'($urandom_range(0, 1) * 15) : 16'($urandom_range(1, 4)));
                    if ($urandom_range(0, 7) == 0)
                        write_reg(CFG_SPARE, clamp16($urandom_range(0, FULL_COUNT)));
                end
            endcase
            burst = (phase == 0) || ($urandom_range(0, 3) == 0);

            if (phase < 3 || $urandom_range(0, 3) != 0) begin
                level = pick_level();
                push_item(pad_item(CMD_RESTART, clamp16($urandom_range(0, FULL_COUNT))),
                          sender_gap(burst), 1'b0, NO_REPORT);
                // Now and then the calibration is cut short by another restart.
                if ($urandom_range(0, 4) == 0) begin
                    cut = $urandom_range(1, CALIB_SAMPLES_DEF - 1);
                    repeat (cut)
                        push_item(pad_item(CMD_SAMPLE, cal_sample(level)), sender_gap(burst),
                                  1'b0, NO_REPORT);
                    push_item(pad_item(CMD_RESTART, clamp16($urandom_range(0, FULL_COUNT))),
                              sender_gap(burst), 1'b0, NO_REPORT);
                end
                repeat (CALIB_SAMPLES_DEF)
                    push_item(pad_item(CMD_SAMPLE, cal_sample(level)), sender_gap(burst),
                              1'b0, NO_REPORT);
            end

            if (phase == 0) begin
                // The output side holds off while the input keeps offering items.
                i_in_valid <= 1'b0;
                hold_asks++;
                do @(posedge i_clk); while (hold_done != hold_asks);
            end

            scan_len = (phase == 0) ? 40 : $urandom_range(8, 30);
            repeat (scan_len) begin
                if ($urandom_range(0, 39) == 0)
                    push_item(pad_item(CMD_RESTART, clamp16($urandom_range(0, FULL_COUNT))),
                              sender_gap(burst), 1'b0, NO_REPORT);
                else
                    push_item(pad_item(CMD_SAMPLE, scan_sample()), sender_gap(burst),
                              1'b0, NO_REPORT);
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Drove %0d items; checked %0d results (%0d calibrations, %0d new touches).",
                 items_sent, reports_checked, cal_reports, new_touches);
        $display("Covered register extremes, both group size limits, restarts %s",
                 "inside calibration and a long output hold-off.");
        if (errors == 0)
            $display("touch_pad_calibrate_and_detect verification clean");
        else
            $display("touch_pad_calibrate_and_detect verification failed");
        $finish;
    end

endmodule

// ----- touch_pad_calibrate_and_detect.f -----
+incdir+design
design/tpcd_pkg.sv
design/tpcd_cell.sv
design/tpcd_div6.sv
design/touch_pad_calibrate_and_detect.sv
design/tpcd_checker.sv
tb/touch_pad_calibrate_and_detect_tb.sv
